// ===== src/hrl_pkg.sv =====
// ----------------------------------------------------------------------------
// hrl_pkg
// shared types and constants of the hex record loader
// ----------------------------------------------------------------------------
`default_nettype none

package hrl_pkg;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_RANGE    = 3'd1;
   localparam logic [2:0] KIND_CHECKSUM = 3'd2;
   localparam logic [2:0] KIND_END      = 3'd3;
   localparam logic [2:0] KIND_FORMAT   = 3'd4;

   localparam logic [7:0] TYPE_DATA    = 8'h00;
   localparam logic [7:0] TYPE_EOF     = 8'h01;
   localparam logic [7:0] TYPE_SEGMENT = 8'h02;

   // classified character
   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
      logic       is_colon;
      logic       is_newline;
   } hrl_char_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [31:0] range_size;
      logic [15:0] line_number;
      logic        last;
   } hrl_result_type;

endpackage

`default_nettype wire

// ===== src/hrl_front.sv =====
// ----------------------------------------------------------------------------
// hrl_front
// request side: classifies each character and pushes it into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_front
   import hrl_pkg::*;
(
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         queue_full,
   output logic              queue_push,
   output hrl_char_type      queue_char
);

   logic is_digit;
   logic is_upper;
   logic is_lower;

   always_comb begin
      is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      is_upper = (req_tdata >= CHAR_UPPER_A) && (req_tdata <= CHAR_UPPER_F);
      is_lower = (req_tdata >= CHAR_LOWER_A) && (req_tdata <= CHAR_LOWER_F);
      queue_char.is_hex     = is_digit || is_upper || is_lower;
      queue_char.nibble     = is_digit ? req_tdata[3:0] : req_tdata[3:0] + 4'd9;
      queue_char.is_colon   = (req_tdata == CHAR_COLON);
      queue_char.is_newline = (req_tdata == CHAR_NEWLINE);
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

endmodule

`default_nettype wire

// ===== src/hrl_queue.sv =====
// ----------------------------------------------------------------------------
// hrl_queue
// short first-in first-out queue of classified characters
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_queue
   import hrl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire hrl_char_type push_char,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output hrl_char_type      head_char
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hrl_char_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_char = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_char;
      end
   end

endmodule

`default_nettype wire

// ===== src/hrl_back.sv =====
// ----------------------------------------------------------------------------
// hrl_back
// record parser: walks the record fields, tracks ranges, drives the results
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_back
   import hrl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data,
   input  wire logic         queue_valid,
   input  wire hrl_char_type queue_char,
   output logic              queue_pop,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   output hrl_result_type    rsp_result
);

   typedef enum logic [2:0] {
      PH_LINE,
      PH_SKIP,
      PH_LEN,
      PH_OFS,
      PH_TYPE,
      PH_DATA,
      PH_SEG,
      PH_CHK
   } record_phase_type;

   record_phase_type phase_ff, phase_in;
   logic        nib_pending_ff, nib_pending_in;
   logic [3:0]  nib_value_ff, nib_value_in;
   logic [7:0]  body_ff, body_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  rec_type_ff, rec_type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] segment_ff, segment_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [31:0] range_start_ff, range_start_in;
   logic [31:0] range_count_ff, range_count_in;
   logic        pending_ff, pending_in;
   logic        restart_ff, restart_in;
   logic [15:0] line_ff, line_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] base_ff;
   logic        second_ff, second_in;
   logic        rsp_valid_ff;
   hrl_result_type rsp_ff, rsp_in;

   logic [1:0]  n_res;
   hrl_result_type res0, res1;
   logic [7:0]  byte_val;
   logic [7:0]  sum_new;
   logic [8:0]  body_next;
   logic [31:0] rec_addr;
   logic        can_load;
   logic        commit;
   logic        load_rsp;

   assign can_load   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      phase_in       = phase_ff;
      nib_pending_in = nib_pending_ff;
      nib_value_in   = nib_value_ff;
      body_in        = body_ff;
      length_in      = length_ff;
      offset_in      = offset_ff;
      rec_type_in    = rec_type_ff;
      sum_in         = sum_ff;
      segment_in     = segment_ff;
      next_addr_in   = next_addr_ff;
      range_start_in = range_start_ff;
      range_count_in = range_count_ff;
      pending_in     = pending_ff;
      restart_in     = restart_ff;
      line_in        = line_ff;
      stopped_in     = stopped_ff;
      n_res          = 2'd0;
      res0           = '0;
      res1           = '0;
      res0.line_number = line_ff;
      res1.line_number = line_ff;
      byte_val  = {nib_value_ff, queue_char.nibble};
      sum_new   = sum_ff + byte_val;
      body_next = {1'b0, body_ff} + 9'd1;
      rec_addr  = {12'h000, segment_ff, 4'h0} + {16'h0000, offset_ff} + base_ff;

      if (!stopped_ff) begin
         unique case (phase_ff)
            PH_LINE: begin
               if (line_ff != 16'hFFFF) begin
                  line_in = line_ff + 16'd1;
               end
               if (queue_char.is_colon) begin
                  phase_in       = PH_LEN;
                  nib_pending_in = 1'b0;
                  sum_in         = '0;
                  offset_in      = '0;
               end else if (!queue_char.is_newline) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (queue_char.is_newline) begin
                  phase_in = PH_LINE;
               end
            end
            default: begin
               if (!queue_char.is_hex) begin
                  n_res      = 2'd1;
                  res0.kind  = KIND_FORMAT;
                  stopped_in = 1'b1;
               end else if (!nib_pending_ff) begin
                  nib_pending_in = 1'b1;
                  nib_value_in   = queue_char.nibble;
               end else begin
                  nib_pending_in = 1'b0;
                  sum_in         = sum_new;
                  unique case (phase_ff)
                     PH_LEN: begin
                        length_in = byte_val;
                        body_in   = '0;
                        phase_in  = PH_OFS;
                     end
                     PH_OFS: begin
                        offset_in = {offset_ff[7:0], byte_val};
                        body_in   = body_next[7:0];
                        if (body_next >= 9'd2) begin
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_TYPE: begin
                        rec_type_in = byte_val;
                        if (restart_ff || (next_addr_ff != rec_addr)) begin
                           if (pending_ff) begin
                              n_res           = 2'd1;
                              res0.kind       = KIND_RANGE;
                              res0.address    = range_start_ff;
                              res0.range_size = range_count_ff;
                              pending_in      = 1'b0;
                           end
                           range_start_in = rec_addr;
                           next_addr_in   = rec_addr;
                           range_count_in = '0;
                           restart_in     = 1'b0;
                        end
                        body_in = '0;
                        if (byte_val == TYPE_DATA) begin
                           phase_in = (length_ff == 8'd0) ? PH_CHK : PH_DATA;
                        end else if (byte_val == TYPE_SEGMENT) begin
                           phase_in = PH_SEG;
                        end else begin
                           phase_in = PH_CHK;
                        end
                     end
                     PH_DATA: begin
                        n_res          = 2'd1;
                        res0.kind      = KIND_DATA;
                        res0.address   = next_addr_ff;
                        res0.data_byte = byte_val;
                        next_addr_in   = next_addr_ff + 32'd1;
                        if (range_count_ff != 32'hFFFF_FFFF) begin
                           range_count_in = range_count_ff + 32'd1;
                        end
                        pending_in = 1'b1;
                        body_in    = body_next[7:0];
                        if (body_next >= {1'b0, length_ff}) begin
                           phase_in = PH_CHK;
                        end
                     end
                     PH_SEG: begin
                        segment_in = {segment_ff[7:0], byte_val};
                        body_in    = body_next[7:0];
                        if (body_next >= 9'd2) begin
                           phase_in = PH_CHK;
                        end
                     end
                     default: begin
                        if (sum_new != 8'd0) begin
                           n_res      = 2'd1;
                           res0.kind  = KIND_CHECKSUM;
                           stopped_in = 1'b1;
                        end else if (rec_type_ff == TYPE_EOF) begin
                           stopped_in = 1'b1;
                           if (pending_ff) begin
                              n_res           = 2'd2;
                              res0.kind       = KIND_RANGE;
                              res0.address    = range_start_ff;
                              res0.range_size = range_count_ff;
                              res1.kind       = KIND_END;
                              pending_in      = 1'b0;
                           end else begin
                              n_res     = 2'd1;
                              res0.kind = KIND_END;
                           end
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  endcase
               end
            end
         endcase
      end

      // a character with two results is held in the queue until its second result is loaded
      commit    = queue_valid && can_load && !((n_res == 2'd2) && !second_ff);
      load_rsp  = queue_valid && can_load && (n_res != 2'd0);
      second_in = second_ff;
      rsp_in    = res0;
      if (queue_valid && can_load) begin
         if (n_res == 2'd2) begin
            second_in = !second_ff;
            rsp_in    = second_ff ? res1 : res0;
         end
         rsp_in.last = (n_res != 2'd2) || second_ff;
      end
   end

   assign queue_pop = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         nib_pending_ff <= 1'b0;
         body_ff        <= '0;
         length_ff      <= '0;
         offset_ff      <= '0;
         rec_type_ff    <= '0;
         sum_ff         <= '0;
         segment_ff     <= '0;
         next_addr_ff   <= '0;
         range_start_ff <= '0;
         range_count_ff <= '0;
         pending_ff     <= 1'b0;
         restart_ff     <= 1'b1;
         line_ff        <= '0;
         stopped_ff     <= 1'b0;
         base_ff        <= '0;
         second_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (commit) begin
            phase_ff       <= phase_in;
            nib_pending_ff <= nib_pending_in;
            body_ff        <= body_in;
            length_ff      <= length_in;
            offset_ff      <= offset_in;
            rec_type_ff    <= rec_type_in;
            sum_ff         <= sum_in;
            segment_ff     <= segment_in;
            next_addr_ff   <= next_addr_in;
            range_start_ff <= range_start_in;
            range_count_ff <= range_count_in;
            pending_ff     <= pending_in;
            restart_ff     <= restart_in;
            line_ff        <= line_in;
            stopped_ff     <= stopped_in;
         end
         second_ff <= second_in;
         if (can_load) begin
            rsp_valid_ff <= load_rsp;
         end
      end
      if (commit) begin
         nib_value_ff <= nib_value_in;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// hex_record_loader
// streaming loader for colon hex records, one character per request
// ----------------------------------------------------------------------------
// req channel: one text character per request in req_tdata[7:0]; lines not
// starting with a colon are skipped, records give data bytes with addresses
// segment*16 + offset + base address.
// rsp channel: results with the kind in rsp_tuser and tlast on the final
// result of a character; data bytes, closed ranges, end record and errors.
// csr port: csr_wr_en writes csr_wr_data to the base address; the user must
// write it only while idle, as the block itself does not enforce this.
// throughput: one character per cycle unless the rsp side stalls; the
// character completing an end record that closes an open range is held in the
// queue until both of its results are loaded. a character passes the queue and
// then the parser output register before its first result shows on rsp_tvalid.
// reset: parser back to line start, queue emptied, base address zero.
// after an error or an end record no more results appear until reset, while
// characters are still taken and dropped.
// a stalled rsp side fills the QUEUE_DEPTH entry queue, then drops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_loader
   import hrl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // ch
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [87:0]       rsp_tdata,    // address, data_byte, range_size, line_number
   output logic [2:0]        rsp_tuser,    // result_kind
   output logic              rsp_tlast
);

   hrl_char_type   push_char;
   hrl_char_type   head_char;
   hrl_result_type result;
   logic           push;
   logic           pop;
   logic           full;
   logic           not_empty;

   hrl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (full),
      .queue_push (push),
      .queue_char (push_char)
   );

   hrl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_char (push_char),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_char (head_char)
   );

   hrl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_valid (not_empty),
      .queue_char  (head_char),
      .queue_pop   (pop),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_result  (result)
   );

   assign rsp_tdata = {result.line_number, result.range_size, result.data_byte, result.address};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

`default_nettype wire

// ===== src/hrl_checker.sv =====
// ----------------------------------------------------------------------------
// hrl_checker
// port level checks of the hex record loader, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_checker
   import hrl_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [87:0]  rsp_tdata,
   input wire logic [2:0]   rsp_tuser,
   input wire logic         rsp_tlast
);

   // no result straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // end record and errors close the stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_END || rsp_tuser == KIND_CHECKSUM
         || rsp_tuser == KIND_FORMAT) |-> rsp_tlast && (rsp_tdata[71:0] == 72'd0))
      else $error("terminal result malformed");

   // nothing follows a terminal result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == KIND_END || rsp_tuser == KIND_CHECKSUM
         || rsp_tuser == KIND_FORMAT) |=> !rsp_tvalid)
      else $error("result after stop");

   // a range report is never the last result of an end record character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == KIND_RANGE) && !rsp_tlast
         |=> rsp_tvalid && (rsp_tuser == KIND_END))
      else $error("range report not followed by end record");

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives hex record text through hex_record_loader one character per request
// and checks every result against a decoder of the same record format
// ----------------------------------------------------------------------------

module testbench;
   import hrl_pkg::*;

   localparam logic [7:0] CHAR_RETURN        = 8'h0D;
   localparam logic [7:0] TYPE_FIRST_UNKNOWN = 8'h03;
   localparam logic [7:0] TYPE_LAST_UNKNOWN  = 8'hFF;

   typedef enum logic [2:0] {
      LINE_START, LINE_SKIP, GET_LENGTH, GET_OFFSET,
      GET_TYPE, GET_DATA, GET_SEGMENT, GET_CHECKSUM
   } parse_phase_type;

   class record_decoder;
      logic [31:0]     base;
      parse_phase_type phase;
      bit             nib_pending;
      logic [3:0]     nib_hold;
      logic [7:0]     idx, rec_len, rec_type, sum;
      logic [15:0]    offset, segment, line_count;
      logic [31:0]    next_addr, range_start, range_count;
      bit             bytes_open, restart, halted;
      hrl_result_type due_results[$];
      hrl_result_type fresh[$];
      int             mismatch_total;

      function new();
         base = '0;
         phase = LINE_START;
         nib_pending = 1'b0;
         nib_hold = '0;
         idx = '0;
         rec_len = '0;
         rec_type = '0;
         sum = '0;
         offset = '0;
         segment = '0;
         line_count = '0;
         next_addr = '0;
         range_start = '0;
         range_count = '0;
         bytes_open = 1'b0;
         restart = 1'b1;
         halted = 1'b0;
         mismatch_total = 0;
      endfunction

      function void set_base(logic [31:0] value);
         base = value;
      endfunction

      function bit hex_digit(logic [7:0] c, output logic [3:0] v);
         v = '0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = 4'(c - CHAR_ZERO);
            return 1'b1;
         end
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = 4'(c - CHAR_UPPER_A + 8'd10);
            return 1'b1;
         end
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            v = 4'(c - CHAR_LOWER_A + 8'd10);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void emit(logic [2:0] kind, logic [31:0] addr, logic [7:0] value,
                         logic [31:0] size);
         hrl_result_type r;
         r.kind = kind;
         r.address = addr;
         r.data_byte = value;
         r.range_size = size;
         r.line_number = line_count;
         r.last = 1'b0;
         fresh.push_back(r);
      endfunction

      function void close_range();
         if (bytes_open) begin
            emit(KIND_RANGE, range_start, '0, range_count);
            bytes_open = 1'b0;
         end
      endfunction

      function void take_byte(logic [7:0] b);
         logic [31:0] addr;
         sum = sum + b;
         case (phase)
            GET_LENGTH: begin
               rec_len = b;
               idx = '0;
               phase = GET_OFFSET;
            end
            GET_OFFSET: begin
               offset = {offset[7:0], b};
               idx++;
               if (idx >= 8'd2) phase = GET_TYPE;
            end
            GET_TYPE: begin
               // continuity is judged with the segment in force before this record
               addr = {12'h000, segment, 4'h0} + {16'h0000, offset} + base;
               rec_type = b;
               if (next_addr != addr) restart = 1'b1;
               if (restart) begin
                  close_range();
                  range_start = addr;
                  next_addr = addr;
                  range_count = '0;
                  restart = 1'b0;
               end
               idx = '0;
               if (b == TYPE_DATA) phase = (rec_len == 8'd0) ? GET_CHECKSUM : GET_DATA;
               else if (b == TYPE_SEGMENT) phase = GET_SEGMENT;
               else phase = GET_CHECKSUM;
            end
            GET_DATA: begin
               emit(KIND_DATA, next_addr, b, '0);
               next_addr = next_addr + 32'd1;
               if (range_count != '1) range_count = range_count + 32'd1;
               bytes_open = 1'b1;
               idx++;
               if (idx >= rec_len) phase = GET_CHECKSUM;
            end
            GET_SEGMENT: begin
               segment = {segment[7:0], b};
               idx++;
               if (idx >= 8'd2) phase = GET_CHECKSUM;
            end
            default: begin
               if (sum != 8'd0) begin
                  emit(KIND_CHECKSUM, '0, '0, '0);
                  halted = 1'b1;
               end else if (rec_type == TYPE_EOF) begin
                  close_range();
                  emit(KIND_END, '0, '0, '0);
                  halted = 1'b1;
               end else begin
                  phase = LINE_SKIP;
               end
            end
         endcase
      endfunction

      function void take_char(logic [7:0] c);
         logic [3:0]     v;
         hrl_result_type r;
         if (halted) return;
         fresh.delete();
         if (phase == LINE_START) begin
            if (line_count != 16'hFFFF) line_count++;
            if (c == CHAR_COLON) begin
               phase = GET_LENGTH;
               nib_pending = 1'b0;
               sum = '0;
               offset = '0;
            end else if (c != CHAR_NEWLINE) begin
               phase = LINE_SKIP;
            end
         end else if (phase == LINE_SKIP) begin
            if (c == CHAR_NEWLINE) phase = LINE_START;
         end else if (!hex_digit(c, v)) begin
            emit(KIND_FORMAT, '0, '0, '0);
            halted = 1'b1;
         end else if (nib_pending) begin
            nib_pending = 1'b0;
            take_byte({nib_hold, v});
         end else begin
            nib_pending = 1'b1;
            nib_hold = v;
         end
         if (fresh.size() != 0) begin
            r = fresh.pop_back();
            r.last = 1'b1;
            fresh.push_back(r);
            foreach (fresh[i]) due_results.push_back(fresh[i]);
         end
      endfunction

      function string describe(hrl_result_type r);
         return $sformatf("kind %0d addr %h byte %h size %h line %0d last %0d",
                          r.kind, r.address, r.data_byte, r.range_size, r.line_number,
                          r.last);
      endfunction

      function void match_result(logic [2:0] kind, logic [87:0] payload, logic tail);
         hrl_result_type got, want;
         got.kind = kind;
         got.address = payload[31:0];
         got.data_byte = payload[39:32];
         got.range_size = payload[71:40];
         got.line_number = payload[87:72];
         got.last = tail;
         if (due_results.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10) $display("unexpected result: %s", describe(got));
         end else begin
            want = due_results.pop_front();
            if (got !== want) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("result mismatch: expected %s, got %s", describe(want),
                           describe(got));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   record_decoder dec;
   logic [7:0]    line_buf[$];
   bit            send_gaps, recv_gaps, hold_request;
   logic [15:0]   gen_next_ofs;
   int            stream_chars;

   hex_record_loader dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side ready, random stall bursts and one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready = 1'b1;
         end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) dec.match_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return CHAR_ZERO + 8'(n);
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic void add_hex(logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CHAR_NEWLINE) c = 8'hFF;
      return c;
   endfunction

   task automatic send_char(logic [7:0] c);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = c;
      do @(posedge clock); while (!req_tready);
      dec.take_char(c);
      @(negedge clock);
   endtask

   task automatic send_line();
      logic [7:0] c;
      stream_chars += line_buf.size();
      while (line_buf.size() != 0) begin
         c = line_buf.pop_front();
         send_char(c);
      end
   endtask

   task automatic put_record(logic [7:0] len, logic [15:0] ofs, logic [7:0] kind,
                             logic [15:0] seg, bit bad_sum);
      logic [7:0] sum, b;
      int         n;
      line_buf.push_back(CHAR_COLON);
      add_hex(len);
      add_hex(ofs[15:8]);
      add_hex(ofs[7:0]);
      add_hex(kind);
      sum = len + ofs[15:8] + ofs[7:0] + kind;
      n = (kind == TYPE_DATA) ? int'(len) : ((kind == TYPE_SEGMENT) ? 2 : 0);
      for (int i = 0; i < n; i++) begin
         if (kind == TYPE_SEGMENT) b = (i == 0) ? seg[15:8] : seg[7:0];
         else b = 8'($urandom_range(0, 255));
         add_hex(b);
         sum = sum + b;
      end
      add_hex(8'(-sum) ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00));
      case ($urandom_range(0, 3))
         1: line_buf.push_back(CHAR_RETURN);
         2: repeat ($urandom_range(1, 4)) line_buf.push_back(text_char());
         default: ;
      endcase
      line_buf.push_back(CHAR_NEWLINE);
      if (kind == TYPE_DATA) gen_next_ofs = ofs + 16'(len);
      send_line();
   endtask

   task automatic put_noise_line(bit blank);
      logic [7:0] c;
      if (!blank) begin
         c = text_char();
         while (c == CHAR_COLON) c = text_char();
         line_buf.push_back(c);
         repeat ($urandom_range(0, 20)) line_buf.push_back(text_char());
      end
      line_buf.push_back(CHAR_NEWLINE);
      send_line();
   endtask

   // only while nothing is in flight
   task automatic set_base(logic [31:0] value);
      req_tvalid = 1'b0;
      while (dec.due_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      dec.set_base(value);
   endtask

   initial begin
      logic [7:0]  len, kind, c;
      logic [15:0] ofs, seg;
      logic [3:0]  v;
      int          pick, recs, mode;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      gen_next_ofs = '0;
      stream_chars = 0;
      dec = new();
      repeat (3) @(negedge clock);
      reset = 1'b0;
      set_base(32'h0000_0000);

      put_noise_line(1'b1);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h7F);
      line_buf.push_back(CHAR_RETURN);
      line_buf.push_back(CHAR_NEWLINE);
      send_line();
      put_record(8'd1, 16'h0000, TYPE_DATA, '0, 1'b0);
      put_record(8'd4, 16'h0001, TYPE_DATA, '0, 1'b0);
      put_record(8'd0, 16'h0005, TYPE_DATA, '0, 1'b0);
      put_record(8'd2, 16'h0000, TYPE_SEGMENT, 16'hFFFF, 1'b0);
      put_record(8'd3, 16'hFFFF, TYPE_DATA, '0, 1'b0);
      put_record(8'd4, 16'h0100, TYPE_FIRST_UNKNOWN, '0, 1'b0);
      put_record(8'd0, 16'h0000, TYPE_LAST_UNKNOWN, '0, 1'b0);
      put_record(8'd2, 16'h0000, TYPE_SEGMENT, 16'h0000, 1'b0);
      put_noise_line(1'b0);
      // long receiver hold-off while a full-length record streams in
      hold_request = 1'b1;
      put_record(8'd255, 16'h1234, TYPE_DATA, '0, 1'b0);
      put_record(8'd16, gen_next_ofs, TYPE_DATA, '0, 1'b0);
      set_base(32'hFFFF_FFFF);
      put_record(8'd2, 16'h0000, TYPE_DATA, '0, 1'b0);
      set_base(32'hFFFF_FFF0);
      // range runs across the top of the address space
      put_record(8'd8, 16'h000C, TYPE_DATA, '0, 1'b0);
      put_record(8'd1, 16'h0014, TYPE_DATA, '0, 1'b0);
      put_record(8'd6, 16'h0000, TYPE_SEGMENT, 16'h8000, 1'b0);

      recs = 0;
      while (stream_chars < 2000) begin
         send_gaps = (stream_chars < 1600) && ($urandom_range(0, 7) != 0);
         recv_gaps = send_gaps;
         if (recs % 30 == 29) begin
            case ($urandom_range(0, 3))
               0: set_base(32'h0000_0000);
               1: set_base(32'hFFFF_FFFF);
               2: set_base(32'hFFFF_F000 | 32'($urandom_range(0, 4095)));
               default: set_base(32'($urandom));
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 19))
               0: len = 8'd0;
               1: len = 8'($urandom_range(17, 255));
               default: len = 8'($urandom_range(1, 16));
            endcase
            ofs = ($urandom_range(0, 9) < 6) ? gen_next_ofs : 16'($urandom_range(0, 65535));
            put_record(len, ofs, TYPE_DATA, '0, 1'b0);
         end else if (pick < 78) begin
            case ($urandom_range(0, 3))
               0: seg = 16'h0000;
               1: seg = 16'hFFFF;
               default: seg = 16'($urandom_range(0, 65535));
            endcase
            len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'd2;
            put_record(len, 16'($urandom_range(0, 65535)), TYPE_SEGMENT, seg, 1'b0);
         end else if (pick < 85) begin
            kind = 8'($urandom_range(TYPE_FIRST_UNKNOWN, TYPE_LAST_UNKNOWN));
            put_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), kind, '0,
                       1'b0);
         end else begin
            put_noise_line(pick >= 95);
         end
         recs++;
      end

      // one way to stop the block, then characters it must drop
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      mode = $urandom_range(0, 4);
      case (mode)
         0: begin
            put_record(8'($urandom_range(1, 8)), gen_next_ofs, TYPE_DATA, '0, 1'b0);
            put_record(8'd0, gen_next_ofs, TYPE_EOF, '0, 1'b0);
         end
         1: put_record(8'd0, 16'h0000, TYPE_EOF, '0, 1'b0);
         2: put_record(8'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)), TYPE_DATA,
                       '0, 1'b1);
         3: begin
            line_buf.push_back(CHAR_COLON);
            add_hex(8'($urandom_range(0, 255)));
            add_hex(8'($urandom_range(0, 255)));
            c = text_char();
            while (dec.hex_digit(c, v)) c = text_char();
            line_buf.push_back(c);
            line_buf.push_back(CHAR_NEWLINE);
            send_line();
         end
         default: begin
            line_buf.push_back(CHAR_COLON);
            repeat ($urandom_range(0, 4)) add_hex(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
            line_buf.push_back(CHAR_NEWLINE);
            send_line();
         end
      endcase
      put_record(8'd4, 16'h0000, TYPE_DATA, '0, 1'b0);
      put_noise_line(1'b0);
      put_record(8'd0, 16'h0000, TYPE_EOF, '0, 1'b0);

      req_tvalid = 1'b0;
      while (dec.due_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (dec.mismatch_total == 0 && dec.due_results.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hrl_pkg.sv
src/hrl_front.sv
src/hrl_queue.sv
src/hrl_back.sv
src/hex_record_loader.sv
src/hrl_checker.sv
tb/testbench.sv
